/* rtl/assert_macros.svh */
// Assertion macros shared by the color Sobel magnitude RTL.
// Used by the modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising edge outside reset.
`define CSM_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: check failed");

// The condition must never be true at a rising edge outside reset.
`define CSM_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("%m: forbidden condition seen");

`endif

/* rtl/csm_pkg.sv */
// Package of the color Sobel magnitude block: constants, types and helpers.
// Used by every module of the block but csm_ram; depends on nothing.
package csm_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int IDX_W       = $clog2(MAX_WIDTH);
  localparam int WIDTH_W     = 11;
  localparam int THR_W       = 8;
  localparam int LEVEL_W     = 8;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 11;
  localparam int QUEUE_DEPTH = 2;
  localparam int PIX_W       = 24;

  localparam logic [WIDTH_W-1:0] WIDTH_RESET = 11'd640;
  localparam logic [THR_W-1:0]   THR_RESET   = 8'd20;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH   = 1'b0,
    CFG_MAG_THRESHOLD = 1'b1
  } cfg_index_t;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_FLUSH = 1'b1
  } op_t;

  typedef logic [PIX_W-1:0] pix_t;

  typedef struct packed {
    pix_t top;
    pix_t mid;
    pix_t bot;
  } col_t;

  typedef struct packed {
    col_t left;
    col_t centre;
    col_t right;
    logic zero;
    logic eor;
    logic eof;
  } job_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_PIX,
    F_PIX2,
    F_FL0,
    F_FL1,
    F_FL2
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_CHAN,
    B_THR,
    B_ROOT,
    B_DONE
  } back_state_t;

  function automatic logic [7:0] sample(input pix_t p, input logic [1:0] k);
    logic [7:0] s;
    case (k)
      2'd0:    s = p[7:0];
      2'd1:    s = p[15:8];
      default: s = p[23:16];
    endcase
    return s;
  endfunction

endpackage

/* rtl/csm_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; used for the two line stores.
module csm_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* rtl/csm_queue.sv */
// Short job queue between the window front end and the gradient back end.
// Depends on csm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module csm_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  csm_pkg::job_t push_data,
  output logic          full,
  input  logic          pop,
  output csm_pkg::job_t pop_data,
  output logic          empty
);
  import csm_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  job_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;

  assign full     = (count == (PTR_W+1)'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `CSM_NEVER(a_no_push_full, clk, rst, push && full)
  `CSM_NEVER(a_no_pop_empty, clk, rst, pop && empty)
  `CSM_NEVER(a_count_range, clk, rst, count > (PTR_W+1)'(QUEUE_DEPTH))

endmodule

/* rtl/csm_front.sv */
// Front end: takes pixels and flush items, keeps the line stores and window,
// and queues one gradient job per result. Depends on csm_pkg and csm_ram.
module csm_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       operation,
  input  logic [7:0]                 red,
  input  logic [7:0]                 green,
  input  logic [7:0]                 blue,
  input  logic [csm_pkg::IDX_W-1:0]  width_m1,
  output logic                       push,
  output csm_pkg::job_t              push_data,
  input  logic                       full
);
  import csm_pkg::*;

  front_state_t     state, state_next;
  logic [IDX_W-1:0] addr_reg, addr_next;
  logic [IDX_W-1:0] column_count;
  logic [IDX_W-1:0] flush_count;
  logic [1:0]       rows_seen;
  pix_t             cur_reg;
  col_t             win_new, win_old;
  col_t             colbuf0, colbuf1;
  pix_t             older_rd, newer_rd;
  logic             commit_pix, commit_fl;

  logic             last_pix, last_fl, need_a, need_b;
  logic [IDX_W-1:0] idx0, idx2;
  col_t             colp, colf;
  pix_t             nb;
  job_t             job_a, job_b, job_f;

  csm_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_older (
    .clk     (clk),
    .we      (commit_pix),
    .wr_addr (addr_reg),
    .wr_data (newer_rd),
    .rd_addr (addr_next),
    .rd_data (older_rd)
  );

  csm_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_newer (
    .clk     (clk),
    .we      (commit_pix),
    .wr_addr (addr_reg),
    .wr_data (cur_reg),
    .rd_addr (addr_next),
    .rd_data (newer_rd)
  );

  always_comb begin
    last_pix = (column_count >= width_m1);
    last_fl  = (flush_count >= width_m1);
    need_a   = (rows_seen != 2'd0) && (column_count != '0);
    need_b   = (rows_seen != 2'd0) && last_pix;
    idx0     = (flush_count == '0) ? IDX_W'(1) : flush_count - 1'b1;
    idx2     = last_fl ? flush_count - 1'b1 : flush_count + 1'b1;

    colp.top = rows_seen[1] ? older_rd : cur_reg;
    colp.mid = newer_rd;
    colp.bot = cur_reg;

    nb       = rows_seen[1] ? older_rd : newer_rd;
    colf.top = nb;
    colf.mid = newer_rd;
    colf.bot = nb;

    job_a.left   = (column_count == IDX_W'(1)) ? colp : win_old;
    job_a.centre = win_new;
    job_a.right  = colp;
    job_a.zero   = 1'b0;
    job_a.eor    = 1'b0;
    job_a.eof    = 1'b0;

    job_b.left   = win_new;
    job_b.centre = colp;
    job_b.right  = win_new;
    job_b.zero   = 1'b0;
    job_b.eor    = 1'b1;
    job_b.eof    = 1'b0;

    job_f.left   = colbuf0;
    job_f.centre = colbuf1;
    job_f.right  = colf;
    job_f.zero   = (rows_seen == 2'd0);
    job_f.eor    = last_fl;
    job_f.eof    = last_fl;
  end

  always_comb begin
    state_next = state;
    case (state)
      F_IDLE: begin
        if (in_valid) begin
          state_next = (operation == OP_FLUSH) ? F_FL0 : F_PIX;
        end
      end
      F_PIX: begin
        if (!need_a || !full) begin
          state_next = need_b ? F_PIX2 : F_IDLE;
        end
      end
      F_PIX2: begin
        if (!full) begin
          state_next = F_IDLE;
        end
      end
      F_FL0: state_next = F_FL1;
      F_FL1: state_next = F_FL2;
      F_FL2: begin
        if (!full) begin
          state_next = F_IDLE;
        end
      end
      default: state_next = F_IDLE;
    endcase
  end

  always_comb begin
    push       = 1'b0;
    push_data  = job_a;
    commit_pix = 1'b0;
    commit_fl  = 1'b0;
    addr_next  = addr_reg;
    in_stall   = (state != F_IDLE);
    case (state)
      F_IDLE: begin
        addr_next = (operation == OP_FLUSH) ? idx0 : column_count;
      end
      F_PIX: begin
        push       = need_a && !full;
        commit_pix = need_a ? (!full && !need_b) : !need_b;
      end
      F_PIX2: begin
        push       = !full;
        push_data  = job_b;
        commit_pix = !full;
      end
      F_FL0: addr_next = flush_count;
      F_FL1: addr_next = idx2;
      F_FL2: begin
        push      = !full;
        push_data = job_f;
        commit_fl = !full;
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    addr_reg <= addr_next;
    if (state == F_IDLE && in_valid) begin
      cur_reg <= {blue, green, red};
    end
    if (state == F_FL0) begin
      colbuf0 <= colf;
    end
    if (state == F_FL1) begin
      colbuf1 <= colf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= F_IDLE;
      column_count <= '0;
      flush_count  <= '0;
      rows_seen    <= '0;
      win_new      <= '0;
      win_old      <= '0;
    end else begin
      state <= state_next;
      if (commit_pix) begin
        win_old <= win_new;
        win_new <= colp;
        if (last_pix) begin
          column_count <= '0;
          if (!rows_seen[1]) begin
            rows_seen <= rows_seen + 1'b1;
          end
        end else begin
          column_count <= column_count + 1'b1;
        end
      end
      if (commit_fl) begin
        if (last_fl) begin
          column_count <= '0;
          rows_seen    <= '0;
          flush_count  <= '0;
        end else begin
          flush_count <= flush_count + 1'b1;
        end
      end
    end
  end

endmodule

/* rtl/csm_back.sv */
// Back end: per job, forms the three channel gradients, keeps the largest,
// thresholds it and takes a rounded square root. Depends on csm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module csm_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        empty,
  input  csm_pkg::job_t               pop_data,
  output logic                        pop,
  input  logic [csm_pkg::THR_W-1:0]   threshold,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [csm_pkg::LEVEL_W-1:0] gradient_level,
  output logic                        end_of_row,
  output logic                        end_of_frame
);
  import csm_pkg::*;

  back_state_t  state, state_next;
  job_t         job_reg;
  logic [1:0]   chan;
  logic [20:0]  best;
  logic [11:0]  root;
  logic [3:0]   bit_idx;
  logic         load_out;

  logic [9:0]         l_sum, r_sum, t_sum, b_sum;
  logic signed [10:0] gx, gy;
  logic signed [21:0] gx_sq, gy_sq;
  logic [20:0]        m2;
  logic [15:0]        thr_sq;
  logic [11:0]        cand;
  logic [23:0]        cand_sq;
  logic [12:0]        rounded;
  logic [LEVEL_W-1:0] level;

  always_comb begin
    l_sum = {2'b0, sample(job_reg.left.top, chan)}
          + {1'b0, sample(job_reg.left.mid, chan), 1'b0}
          + {2'b0, sample(job_reg.left.bot, chan)};
    r_sum = {2'b0, sample(job_reg.right.top, chan)}
          + {1'b0, sample(job_reg.right.mid, chan), 1'b0}
          + {2'b0, sample(job_reg.right.bot, chan)};
    t_sum = {2'b0, sample(job_reg.left.top, chan)}
          + {1'b0, sample(job_reg.centre.top, chan), 1'b0}
          + {2'b0, sample(job_reg.right.top, chan)};
    b_sum = {2'b0, sample(job_reg.left.bot, chan)}
          + {1'b0, sample(job_reg.centre.bot, chan), 1'b0}
          + {2'b0, sample(job_reg.right.bot, chan)};
    gx      = $signed({1'b0, r_sum}) - $signed({1'b0, l_sum});
    gy      = $signed({1'b0, b_sum}) - $signed({1'b0, t_sum});
    gx_sq   = gx * gx;
    gy_sq   = gy * gy;
    m2      = {1'b0, gx_sq[19:0]} + {1'b0, gy_sq[19:0]};
    thr_sq  = threshold * threshold;
    cand    = root | (12'd1 << bit_idx);
    cand_sq = cand * cand;
    rounded = ({1'b0, root} + 13'd1) >> 1;
    level   = (rounded > 13'd255) ? LEVEL_W'(255) : rounded[LEVEL_W-1:0];
  end

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: begin
        if (!empty) begin
          state_next = B_CHAN;
        end
      end
      B_CHAN: begin
        if (chan == 2'd2) begin
          state_next = B_THR;
        end
      end
      B_THR: begin
        if (job_reg.zero || best <= {5'b0, thr_sq}) begin
          state_next = B_DONE;
        end else begin
          state_next = B_ROOT;
        end
      end
      B_ROOT: begin
        if (bit_idx == 4'd0) begin
          state_next = B_DONE;
        end
      end
      B_DONE: begin
        if (!out_valid || !out_stall) begin
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    pop      = 1'b0;
    load_out = 1'b0;
    case (state)
      B_IDLE:  pop      = !empty;
      B_DONE:  load_out = !out_valid || !out_stall;
      default: pop      = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job_reg <= pop_data;
    end
    case (state)
      B_IDLE: chan <= 2'd0;
      B_CHAN: begin
        if (chan == 2'd0 || m2 > best) begin
          best <= m2;
        end
        chan <= chan + 1'b1;
      end
      B_THR: begin
        root    <= '0;
        bit_idx <= 4'd11;
      end
      B_ROOT: begin
        if (cand_sq <= {best, 3'b000} >> 1) begin
          root <= cand;
        end
        bit_idx <= bit_idx - 1'b1;
      end
      default: begin
        chan <= chan;
      end
    endcase
    if (load_out) begin
      gradient_level <= level;
      end_of_row     <= job_reg.eor;
      end_of_frame   <= job_reg.eof;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  `CSM_NEVER(a_chan_range, clk, rst, state == B_CHAN && chan == 2'd3)
  `CSM_NEVER(a_root_not_zero_job, clk, rst, state == B_ROOT && job_reg.zero)
  `CSM_ASSERT(a_out_held, clk, rst, out_valid && out_stall |=> out_valid)

endmodule

/* rtl/color_sobel_max_magnitude_core.sv */
// Top level of the color Sobel maximum-magnitude filter.
// Depends on csm_pkg, csm_front, csm_queue and csm_back.
//
// Pixels arrive in raster order, followed by image_width flush items that
// drain the last row; results lag one row and one column, a row-end pixel
// gives two results and each flush item gives one. The front end takes a
// pixel through F_PIX (and F_PIX2 when it yields two results) and a flush
// item through F_FL0, F_FL1 and F_FL2, limited by the single read port of
// each line store. The back end forms the channel gradients, thresholds
// and, above the threshold, runs the bit-serial square root, which sets
// the sustained rate. A two-entry job queue lets the front end keep
// accepting while the back end works. Configuration writes apply at once;
// they are to be made while idle, by the user; the block does not enforce it.
module color_sobel_max_magnitude_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           operation,
  input  logic [7:0]                     red,
  input  logic [7:0]                     green,
  input  logic [7:0]                     blue,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [csm_pkg::LEVEL_W-1:0]    gradient_level,
  output logic                           end_of_row,
  output logic                           end_of_frame,
  input  logic                           cfg_we,
  input  logic [csm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [csm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import csm_pkg::*;

  logic [WIDTH_W-1:0] image_width;
  logic [THR_W-1:0]   magnitude_threshold;
  logic [WIDTH_W-1:0] eff_width;
  logic [IDX_W-1:0]   width_m1;
  logic               push, pop, full, empty;
  job_t               push_data, pop_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width         <= WIDTH_RESET;
      magnitude_threshold <= THR_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:   image_width         <= cfg_data[WIDTH_W-1:0];
        CFG_MAG_THRESHOLD: magnitude_threshold <= cfg_data[THR_W-1:0];
        default:           image_width         <= image_width;
      endcase
    end
  end

  always_comb begin
    if (image_width < WIDTH_W'(2)) begin
      eff_width = WIDTH_W'(2);
    end else if (image_width > WIDTH_W'(MAX_WIDTH)) begin
      eff_width = WIDTH_W'(MAX_WIDTH);
    end else begin
      eff_width = image_width;
    end
    width_m1 = IDX_W'(eff_width - 1'b1);
  end

  csm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .operation (operation),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .width_m1  (width_m1),
    .push      (push),
    .push_data (push_data),
    .full      (full)
  );

  csm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  csm_back u_back (
    .clk            (clk),
    .rst            (rst),
    .empty          (empty),
    .pop_data       (pop_data),
    .pop            (pop),
    .threshold      (magnitude_threshold),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .gradient_level (gradient_level),
    .end_of_row     (end_of_row),
    .end_of_frame   (end_of_frame)
  );

endmodule

/* tb/tb_color_sobel_max_magnitude_core.sv */
// Self-checking testbench for color_sobel_max_magnitude_core: directed and random
// RGB frames, with random idle cycles on both channels, checked against a predictor.
// Depends on csm_pkg and the RTL of the block.
module tb_color_sobel_max_magnitude_core;
  import csm_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int ITEM_COUNT = 1900;

  typedef struct {
    logic [7:0] level;
    logic       eor;
    logic       eof;
  } grad_result_t;

  typedef struct {
    op_t          op;
    logic [7:0]   r;
    logic [7:0]   g;
    logic [7:0]   b;
    bit           typed;
    grad_result_t res;
  } stim_row_t;

  logic clk, rst;
  logic in_valid, in_stall, operation;
  logic [7:0] red, green, blue;
  logic out_valid, out_stall;
  logic [LEVEL_W-1:0] gradient_level;
  logic end_of_row, end_of_frame;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  bit typed_now;
  grad_result_t typed_res;
  int send_idle_pct, recv_stall_pct;
  int errors, cycles, items_sent;

  grad_result_t pending_levels[$];

  pix_t older_rows[MAX_WIDTH];
  pix_t newer_rows[MAX_WIDTH];
  col_t newest_col, prior_col;
  int col_pos, row_cnt, flush_pos;
  int width_reg, thr_reg;

  color_sobel_max_magnitude_core DUT (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int root_floor(int v);
    int r;
    r = 0;
    for (int b = 11; b >= 0; b--) begin
      if ((r | (1 << b)) * (r | (1 << b)) <= v) r = r | (1 << b);
    end
    return r;
  endfunction

  function automatic int chan(pix_t p, int k);
    return int'(p[8*k +: 8]);
  endfunction

  function automatic logic [7:0] max_gradient(col_t lc, col_t mc, col_t rc);
    int best, gx, gy, m2, root;
    best = 0;
    for (int k = 0; k < 3; k++) begin
      gx = (chan(rc.top, k) + 2 * chan(rc.mid, k) + chan(rc.bot, k))
         - (chan(lc.top, k) + 2 * chan(lc.mid, k) + chan(lc.bot, k));
      gy = (chan(lc.bot, k) + 2 * chan(mc.bot, k) + chan(rc.bot, k))
         - (chan(lc.top, k) + 2 * chan(mc.top, k) + chan(rc.top, k));
      m2 = gx * gx + gy * gy;
      if (k == 0 || m2 > best) best = m2;
    end
    if (best <= thr_reg * thr_reg) return 8'd0;
    root = root_floor(best);
    if (best > root * root + root) root++;
    return (root > 255) ? 8'd255 : root[7:0];
  endfunction

  function automatic int active_width();
    if (width_reg < 2) return 2;
    if (width_reg > MAX_WIDTH) return MAX_WIDTH;
    return width_reg;
  endfunction

  function automatic void queue_level(logic [7:0] lvl, logic eor, logic eof);
    grad_result_t res;
    res.level = lvl;
    res.eor = eor;
    res.eof = eof;
    pending_levels.push_back(res);
  endfunction

  function automatic void predict_item(logic op, logic [7:0] r, logic [7:0] g, logic [7:0] b);
    int w, c, k, x;
    bit last;
    pix_t cur, nb;
    col_t cc, lc;
    col_t fc[3];
    int idx[3];
    w = active_width();
    if (op == OP_PIXEL) begin
      c = (col_pos >= MAX_WIDTH) ? MAX_WIDTH - 1 : col_pos;
      cur = {b, g, r};
      last = (c >= w - 1);
      cc.top = (row_cnt >= 2) ? older_rows[c] : cur;
      cc.mid = newer_rows[c];
      cc.bot = cur;
      if (row_cnt >= 1) begin
        if (c >= 1) begin
          lc = (c == 1) ? cc : prior_col;
          queue_level(max_gradient(lc, newest_col, cc), 1'b0, 1'b0);
        end
        if (last) queue_level(max_gradient(newest_col, cc, newest_col), 1'b1, 1'b0);
      end
      older_rows[c] = newer_rows[c];
      newer_rows[c] = cur;
      prior_col = newest_col;
      newest_col = cc;
      if (last) begin
        col_pos = 0;
        if (row_cnt < 2) row_cnt++;
      end else begin
        col_pos = c + 1;
      end
    end else begin
      k = (flush_pos >= MAX_WIDTH) ? MAX_WIDTH - 1 : flush_pos;
      last = (k >= w - 1);
      if (row_cnt >= 1) begin
        idx[0] = (k == 0) ? 1 : k - 1;
        idx[1] = k;
        idx[2] = last ? k - 1 : k + 1;
        for (int j = 0; j < 3; j++) begin
          x = (idx[j] >= MAX_WIDTH) ? MAX_WIDTH - 1 : idx[j];
          nb = (row_cnt >= 2) ? older_rows[x] : newer_rows[x];
          fc[j].top = nb;
          fc[j].mid = newer_rows[x];
          fc[j].bot = nb;
        end
        queue_level(max_gradient(fc[0], fc[1], fc[2]), last, last);
      end else begin
        queue_level(8'd0, last, last);
      end
      if (last) begin
        col_pos = 0;
        row_cnt = 0;
        flush_pos = 0;
      end else begin
        flush_pos = k + 1;
      end
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      predict_item(operation, red, green, blue);
      if (typed_now) pending_levels[pending_levels.size() - 1] = typed_res;
    end
  end

  always @(posedge clk) begin
    grad_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_levels.size() == 0) begin
        $display("%0t: unexpected result level=%0d eor=%0d eof=%0d", $time,
                 gradient_level, end_of_row, end_of_frame);
        errors++;
      end else begin
        want = pending_levels.pop_front();
        if (gradient_level !== want.level || end_of_row !== want.eor ||
            end_of_frame !== want.eof) begin
          $display("%0t: mismatch expected level=%0d eor=%0d eof=%0d, actual level=%0d eor=%0d eof=%0d",
                   $time, want.level, want.eor, want.eof, gradient_level, end_of_row,
                   end_of_frame);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_stall = ($urandom_range(99) < recv_stall_pct);
  end

  task automatic write_reg(cfg_index_t idx, int value);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = value[CFG_DATA_W-1:0];
    @(posedge clk);
    if (idx == CFG_IMAGE_WIDTH) width_reg = value & 11'h7FF;
    else thr_reg = value & 8'hFF;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (pending_levels.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_item(op_t op, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                           bit typed = 0, grad_result_t res = '{0, 0, 0});
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    operation = op;
    red = r;
    green = g;
    blue = b;
    typed_now = typed;
    typed_res = res;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    items_sent++;
    if (items_sent == ITEM_COUNT / 3) begin
      send_idle_pct = 47;
      recv_stall_pct = 35;
    end else if (items_sent == 2 * ITEM_COUNT / 3) begin
      send_idle_pct = 0;
      recv_stall_pct = 0;
    end
  endtask

  function automatic logic [7:0] rand_sample();
    case ($urandom_range(2))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic send_pixel();
    send_item(OP_PIXEL, rand_sample(), rand_sample(), rand_sample());
  endtask

  task automatic send_frame(int rows, bit partial, bit noisy);
    int w;
    w = active_width();
    for (int i = 0; i < rows * w; i++) send_pixel();
    if (partial) begin
      for (int i = $urandom_range(w - 1, 1); i > 0; i--) send_pixel();
    end
    for (int k = 0; k < w; k++) begin
      if (noisy && $urandom_range(7) == 0) send_pixel();
      send_item(OP_FLUSH, 8'd0, 8'd0, 8'd0);
    end
  endtask

  stim_row_t directed_rows[14];

  initial begin
    int thr_pick;
    rst = 1'b1;
    in_valid = 1'b0;
    operation = 1'b0;
    red = 8'd0;
    green = 8'd0;
    blue = 8'd0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    out_stall = 1'b0;
    typed_now = 0;
    typed_res = '{0, 0, 0};
    send_idle_pct = 35;
    recv_stall_pct = 47;
    errors = 0;
    cycles = 0;
    items_sent = 0;
    width_reg = 640;
    thr_reg = 20;
    col_pos = 0;
    row_cnt = 0;
    flush_pos = 0;
    newest_col = '0;
    prior_col = '0;
    for (int i = 0; i < MAX_WIDTH; i++) begin
      older_rows[i] = '0;
      newer_rows[i] = '0;
    end
    directed_rows = '{
      '{OP_FLUSH, 0, 0, 0, 1, '{0, 0, 0}},
      '{OP_FLUSH, 0, 0, 0, 1, '{0, 1, 1}},
      '{OP_PIXEL, 0, 0, 0, 0, '{0, 0, 0}},
      '{OP_PIXEL, 255, 255, 255, 0, '{0, 0, 0}},
      '{OP_FLUSH, 0, 0, 0, 0, '{0, 0, 0}},
      '{OP_FLUSH, 0, 0, 0, 0, '{0, 0, 0}},
      '{OP_PIXEL, 255, 0, 0, 0, '{0, 0, 0}},
      '{OP_PIXEL, 0, 255, 0, 0, '{0, 0, 0}},
      '{OP_PIXEL, 0, 0, 255, 0, '{0, 0, 0}},
      '{OP_PIXEL, 255, 255, 255, 0, '{0, 0, 0}},
      '{OP_PIXEL, 128, 64, 32, 0, '{0, 0, 0}},
      '{OP_FLUSH, 0, 0, 0, 0, '{0, 0, 0}},
      '{OP_PIXEL, 7, 200, 13, 0, '{0, 0, 0}},
      '{OP_FLUSH, 0, 0, 0, 0, '{0, 0, 0}}
    };
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // A width below two acts as two.
    write_reg(CFG_IMAGE_WIDTH, 1);
    write_reg(CFG_MAG_THRESHOLD, 0);
    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].op, directed_rows[i].r, directed_rows[i].g,
                directed_rows[i].b, directed_rows[i].typed, directed_rows[i].res);
    end
    typed_now = 0;

    // One flush-only frame at the largest width; an oversized value is clamped.
    wait_drained();
    write_reg(CFG_IMAGE_WIDTH, 2047);
    write_reg(CFG_MAG_THRESHOLD, 255);
    send_frame(0, 0, 0);

    while (items_sent < ITEM_COUNT) begin
      wait_drained();
      write_reg(CFG_IMAGE_WIDTH, ($urandom_range(9) == 0) ? $urandom_range(40, 9)
                                                          : $urandom_range(8, 2));
      thr_pick = $urandom_range(5);
      write_reg(CFG_MAG_THRESHOLD, (thr_pick == 0) ? 0 : (thr_pick == 1) ? 255
                                   : $urandom_range(60));
      repeat ($urandom_range(3, 1)) begin
        send_frame(($urandom_range(7) == 0) ? 0 : $urandom_range(4, 1),
                   $urandom_range(3) == 0, $urandom_range(4) == 0);
      end
    end

    wait_drained();
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/csm_pkg.sv
rtl/csm_ram.sv
rtl/csm_queue.sv
rtl/csm_front.sv
rtl/csm_back.sv
rtl/color_sobel_max_magnitude_core.sv
tb/tb_color_sobel_max_magnitude_core.sv
